/* rtl/brq_pkg.sv */
// Shared types and constants for the byte ring queue.
// No dependencies; the top, controller, datapath and testbench import it; brq_ram does not.
package brq_pkg;

  localparam int OP_W        = 3;
  localparam int DATA_W      = 8;
  localparam int AMT_W       = 7;
  localparam int CAP_W       = 11;
  localparam int DEPTH_DEF   = 1024;
  localparam int MAX_REQ_DEF = 64;
  localparam int CAP_RESET   = 1024;

  // request codes; 5..7 are unused and answer with one empty result
  typedef enum logic [OP_W-1:0] {
    OP_PUSH      = 3'd0,
    OP_PEEK      = 3'd1,
    OP_POP       = 3'd2,
    OP_PEEK_POP  = 3'd3,
    OP_CLEAR     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic ready;     // input side may take a beat
    logic accept;    // input beat taken this cycle
    logic rd_issue;  // present walk address to the store
    logic rd_emit;   // move store read data into the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;    // output register empty or draining this cycle
    logic walk_start;  // current input beat is a read that returns bytes
    logic walk_last;   // byte being emitted is the final one of the walk
  } dp_stat_t;

endpackage

/* rtl/byte_ring_queue_peek_pop.sv */
// Byte ring queue: push runs, peek, pop, peek-and-pop, clear; capacity set by register.
// Push, pop, clear and empty-read results are on m_axis the cycle after the beat; the first
//   peek byte passes the address state, the registered store read and the output register.
// Throughput: push bytes, pops, clears 1 beat/cycle while m_axis takes results; a peek holds
//   the input for its whole walk, an address and a data state per byte; m_axis stalls add to it.
// Reset (rst, synchronous): queue empty, capacity min(1024, DEPTH), no open run, no clearing.
module byte_ring_queue_peek_pop import brq_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int MAX_REQ = MAX_REQ_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // configuration: capacity register
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  // request stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,  // data_in[7:0], request_count[14:8], 0[15]
  input  logic [OP_W-1:0]  s_axis_tuser,  // op[2:0]
  input  logic             s_axis_tlast,  // push_final
  // result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // status[0], data_out[8:1], amount[15:9],
                                          // free_space[26:16], is_empty[27],
                                          // is_full[28], 0[31:29]
  output logic             m_axis_tlast   // last
);

  localparam int AW = $clog2(DEPTH);

  ctrl_cmd_t         cmd;
  dp_stat_t          stat;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              o_status;
  logic [DATA_W-1:0] o_data;
  logic [AMT_W-1:0]  o_amount;
  logic [CAP_W-1:0]  o_free;
  logic              o_empty;
  logic              o_full;

  // FSM: IDLE takes beats; a peek walk loops ADDR -> DATA per byte
  brq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .stat     (stat),
    .cmd      (cmd)
  );

  brq_dp #(
    .DEPTH   (DEPTH),
    .MAX_REQ (MAX_REQ)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_op      (s_axis_tuser),
    .in_data    (s_axis_tdata[7:0]),
    .in_req     (s_axis_tdata[14:8]),
    .in_final   (s_axis_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (o_status),
    .out_data   (o_data),
    .out_amount (o_amount),
    .out_free   (o_free),
    .out_empty  (o_empty),
    .out_full   (o_full),
    .out_last   (m_axis_tlast)
  );

  // byte store; only slots written by a push are ever read back
  brq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_axis_tready = cmd.ready;
  assign m_axis_tdata  = {3'b000, o_full, o_empty, o_free, o_amount, o_data, o_status};

`ifndef SYNTHESIS
  // capacity is never zero, so a queue cannot be both empty and full
  a_empty_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(o_empty && o_full))
    else $error("result beat flags empty and full together");

  // every walk step lands a beat in the output register
  a_emit_beat: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_emit |=> m_axis_tvalid)
    else $error("walk byte emitted but no result beat");

  // a read issue is always followed by its data cycle
  a_issue_gap: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |=> (!cmd.rd_issue && !s_axis_tready))
    else $error("store read issued twice or input opened mid walk");
`endif

endmodule

/* rtl/brq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/brq_ctrl.sv */
// Controller FSM: input handshake and the byte walk of peek / peek-and-pop.
// Depends on brq_pkg.
module brq_ctrl import brq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        cmd.ready  = stat.out_free;
        cmd.accept = stat.out_free && in_valid;
        if (cmd.accept && stat.walk_start) begin
          state_next = ST_RD_ADDR;
        end
      end
      ST_RD_ADDR: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        // read data holds in the RAM output until the next issue
        if (stat.out_free) begin
          cmd.rd_emit = 1'b1;
          state_next  = stat.walk_last ? ST_IDLE : ST_RD_ADDR;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/brq_dp.sv */
// Datapath: ring indexes, free count, push-run state, walk counters and
// the output register. Depends on brq_pkg; drives the store ports.
module brq_dp import brq_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int MAX_REQ = MAX_REQ_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_wdata,
  input  logic [OP_W-1:0]          in_op,
  input  logic [DATA_W-1:0]        in_data,
  input  logic [AMT_W-1:0]         in_req,
  input  logic                     in_final,
  input  ctrl_cmd_t                cmd,
  output dp_stat_t                 stat,
  output logic                     ram_we,
  output logic [$clog2(DEPTH)-1:0] ram_waddr,
  output logic [DATA_W-1:0]        ram_wdata,
  output logic                     ram_re,
  output logic [$clog2(DEPTH)-1:0] ram_raddr,
  input  logic [DATA_W-1:0]        ram_rdata,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_status,
  output logic [DATA_W-1:0]        out_data,
  output logic [AMT_W-1:0]         out_amount,
  output logic [CAP_W-1:0]         out_free,
  output logic                     out_empty,
  output logic                     out_full,
  output logic                     out_last
);

  localparam int IW = $clog2(DEPTH);
  // wide enough for index + request and for the capacity
  localparam int SW = (IW + 1 > CAP_W) ? IW + 1 : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RST =
    CAP_W'((DEPTH < CAP_RESET) ? DEPTH : CAP_RESET);

  function automatic logic [IW-1:0] inc_wrap(input logic [IW-1:0] idx,
                                              input logic [CAP_W-1:0] cap);
    logic [SW-1:0] s;
    s = SW'(idx) + SW'(1);
    return (s >= SW'(cap)) ? '0 : s[IW-1:0];
  endfunction

  // control state
  logic [CAP_W-1:0] capacity, capacity_next;
  logic [IW-1:0]    write_index, write_index_next;
  logic [IW-1:0]    read_index, read_index_next;
  logic [CAP_W-1:0] free_count, free_count_next;
  logic             in_run, in_run_next;
  logic             run_rej, run_rej_next;
  logic [AMT_W-1:0] run_bytes, run_bytes_next;
  logic [AMT_W-1:0] run_limit, run_limit_next;
  logic             out_valid_next;

  // walk registers
  logic [IW-1:0]    rd_ptr, rd_ptr_next;
  logic [AMT_W-1:0] walk_cnt, walk_cnt_next;
  logic [AMT_W-1:0] walk_n, walk_n_next;

  op_t              op;
  logic [AMT_W-1:0] req_cap;
  logic [CAP_W-1:0] cap_clamp;
  logic             p_start, p_rej, p_store;
  logic [AMT_W-1:0] p_lim, p_bytes, p_bytes_new;
  logic [CAP_W-1:0] stored;
  logic [AMT_W-1:0] n_rd;
  logic [SW-1:0]    rd_sum, rd_wrap;
  logic             is_read;
  logic             load_direct;
  logic             d_status;
  logic [AMT_W-1:0] d_amount;

  assign op      = op_t'(in_op);
  assign req_cap = (in_req > AMT_W'(MAX_REQ)) ? AMT_W'(MAX_REQ) : in_req;

  always_comb begin
    cap_clamp = cfg_wdata;
    if (cfg_wdata == '0) begin
      cap_clamp = CAP_W'(1);
    end else if (32'(cfg_wdata) > 32'(DEPTH)) begin
      cap_clamp = CAP_W'(DEPTH);
    end
  end

  // push run: length checked on the opening byte only
  assign p_start     = !in_run;
  assign p_lim       = p_start ? req_cap : run_limit;
  assign p_rej       = p_start ? (CAP_W'(req_cap) > free_count) : run_rej;
  assign p_bytes     = p_start ? '0 : run_bytes;
  assign p_store     = !p_rej && (p_bytes < p_lim) && (free_count != '0);
  assign p_bytes_new = p_store ? p_bytes + AMT_W'(1) : p_bytes;

  // read request size and new read index
  assign stored  = (capacity >= free_count) ? capacity - free_count : '0;
  assign n_rd    = (CAP_W'(req_cap) > stored) ? stored[AMT_W-1:0] : req_cap;
  assign rd_sum  = SW'(read_index) + SW'(n_rd);
  assign rd_wrap = (rd_sum >= SW'(capacity)) ? rd_sum - SW'(capacity) : rd_sum;
  assign is_read = (op == OP_PEEK) || (op == OP_POP) || (op == OP_PEEK_POP);

  assign stat.out_free   = !out_valid || out_ready;
  assign stat.walk_start = ((op == OP_PEEK) || (op == OP_PEEK_POP)) && (n_rd != '0);
  assign stat.walk_last  = (walk_cnt == walk_n - AMT_W'(1));

  assign load_direct = cmd.accept && ((op == OP_PUSH) ? in_final : !stat.walk_start);
  assign d_status    = (op == OP_PUSH) && p_rej;

  always_comb begin
    d_amount = '0;
    if (op == OP_PUSH) begin
      d_amount = p_rej ? '0 : p_bytes_new;
    end else if (is_read) begin
      d_amount = n_rd;
    end
  end

  assign ram_we    = cmd.accept && (op == OP_PUSH) && p_store;
  assign ram_waddr = write_index;
  assign ram_wdata = in_data;
  assign ram_re    = cmd.rd_issue;
  assign ram_raddr = rd_ptr;

  always_comb begin
    capacity_next    = capacity;
    write_index_next = write_index;
    read_index_next  = read_index;
    free_count_next  = free_count;
    in_run_next      = in_run;
    run_rej_next     = run_rej;
    run_bytes_next   = run_bytes;
    run_limit_next   = run_limit;
    rd_ptr_next      = rd_ptr;
    walk_cnt_next    = walk_cnt;
    walk_n_next      = walk_n;

    if (cfg_we) begin
      capacity_next    = cap_clamp;
      write_index_next = '0;
      read_index_next  = '0;
      free_count_next  = cap_clamp;
      in_run_next      = 1'b0;
      run_rej_next     = 1'b0;
      run_bytes_next   = '0;
      run_limit_next   = '0;
    end else if (cmd.accept) begin
      // any non-push op closes an open run
      in_run_next    = 1'b0;
      run_rej_next   = 1'b0;
      run_bytes_next = '0;
      run_limit_next = '0;
      case (op)
        OP_PUSH: begin
          if (p_store) begin
            write_index_next = inc_wrap(write_index, capacity);
            free_count_next  = free_count - CAP_W'(1);
          end
          if (!in_final) begin
            in_run_next    = 1'b1;
            run_rej_next   = p_rej;
            run_bytes_next = p_bytes_new;
            run_limit_next = p_lim;
          end
        end
        OP_PEEK, OP_POP, OP_PEEK_POP: begin
          if (op != OP_PEEK) begin
            read_index_next = rd_wrap[IW-1:0];
            free_count_next = free_count + CAP_W'(n_rd);
          end
          rd_ptr_next   = read_index;
          walk_cnt_next = '0;
          walk_n_next   = n_rd;
        end
        OP_CLEAR: begin
          write_index_next = '0;
          read_index_next  = '0;
          free_count_next  = capacity;
        end
        default: begin
        end
      endcase
    end else if (cmd.rd_emit) begin
      rd_ptr_next   = inc_wrap(rd_ptr, capacity);
      walk_cnt_next = walk_cnt + AMT_W'(1);
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (load_direct || cmd.rd_emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CAP_RST;
      write_index <= '0;
      read_index  <= '0;
      free_count  <= CAP_RST;
      in_run      <= 1'b0;
      run_rej     <= 1'b0;
      run_bytes   <= '0;
      run_limit   <= '0;
      out_valid   <= 1'b0;
    end else begin
      capacity    <= capacity_next;
      write_index <= write_index_next;
      read_index  <= read_index_next;
      free_count  <= free_count_next;
      in_run      <= in_run_next;
      run_rej     <= run_rej_next;
      run_bytes   <= run_bytes_next;
      run_limit   <= run_limit_next;
      out_valid   <= out_valid_next;
    end
  end

  // payload: walk counters and output beat
  always_ff @(posedge clk) begin
    rd_ptr   <= rd_ptr_next;
    walk_cnt <= walk_cnt_next;
    walk_n   <= walk_n_next;
    if (load_direct) begin
      out_status <= d_status;
      out_data   <= '0;
      out_amount <= d_amount;
      out_free   <= free_count_next;
      out_empty  <= (free_count_next == capacity);
      out_full   <= (free_count_next == '0);
      out_last   <= 1'b1;
    end else if (cmd.rd_emit) begin
      // free count already reflects the whole request
      out_status <= 1'b0;
      out_data   <= ram_rdata;
      out_amount <= walk_n;
      out_free   <= free_count;
      out_empty  <= (free_count == capacity);
      out_full   <= (free_count == '0);
      out_last   <= stat.walk_last;
    end
  end

endmodule

/* verif/tb_byte_ring_queue_peek_pop.sv */
// Self-checking testbench for byte_ring_queue_peek_pop: a directed table, then random push
// runs, reads, clears, unused ops and capacity writes, checked against an in-bench predictor.
// Depends on rtl/brq_pkg.sv and the block files in rtl/.
module tb_byte_ring_queue_peek_pop;
  import brq_pkg::*;

  // op codes with no function: the block answers with one empty result
  localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
  // status codes
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_NO_ROOM = 1'b1;

  // one result beat, fields in the order they sit in m_axis_tdata (plus tlast)
  typedef struct packed {
    logic                status;
    logic [DATA_W-1:0]   data;
    logic [AMT_W-1:0]    amount;
    logic [CAP_W-1:0]    free_space;
    logic                is_empty;
    logic                is_full;
    logic                last;
  } result_t;

  // one row of the directed table: either a capacity write or a request beat
  typedef struct {
    logic              is_cfg;
    logic [CAP_W-1:0]  cfg_val;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] din;
    logic [AMT_W-1:0]  req;
    logic              fin;
    logic              fixed;  // typed-in result replaces the predicted one
    result_t           want;
  } step_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CAP_W-1:0]   cfg_wdata;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata;  // data_in[7:0], request_count[14:8], 0[15]
  logic [OP_W-1:0]    s_axis_tuser;  // op[2:0]
  logic               s_axis_tlast;  // push_final
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [31:0]        m_axis_tdata;  // status, data_out, amount, free_space, is_empty, is_full
  logic               m_axis_tlast;  // last

  byte_ring_queue_peek_pop u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the ring and the open push run
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] ring_mem [DEPTH_DEF];
  int unsigned       ring_cap;
  int unsigned       wr_ptr;
  int unsigned       rd_ptr;
  int unsigned       free_slots;
  bit                run_open;
  bit                run_refused;
  int unsigned       run_stored;
  int unsigned       run_len;

  result_t pending_results [$];  // results still owed by the DUT, oldest first
  int      fail_cnt      = 0;
  int      beats_sent    = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  result_t mon_got;
  result_t mon_exp;
  step_t   dir_tab [$];

  function automatic int unsigned ring_next(int unsigned i);
    return (i + 1 >= ring_cap) ? 0 : i + 1;
  endfunction

  function automatic void close_run();
    run_open    = 0;
    run_refused = 0;
    run_stored  = 0;
    run_len     = 0;
  endfunction

  function automatic void empty_ring();
    wr_ptr     = 0;
    rd_ptr     = 0;
    free_slots = ring_cap;
    close_run();
  endfunction

  // capacity write: 0 acts as 1, anything past the memory depth acts as the depth
  function automatic void apply_capacity(logic [CAP_W-1:0] v);
    if (v == '0) ring_cap = 1;
    else if (32'(v) > DEPTH_DEF) ring_cap = DEPTH_DEF;
    else ring_cap = 32'(v);
    empty_ring();
  endfunction

  // free space and flags are taken after the whole request has been applied
  function automatic void owe_result(logic st, logic [DATA_W-1:0] d, int unsigned amt,
                                     logic lst);
    result_t r;
    r.status     = st;
    r.data       = d;
    r.amount     = amt[AMT_W-1:0];
    r.free_space = free_slots[CAP_W-1:0];
    r.is_empty   = (free_slots == ring_cap);
    r.is_full    = (free_slots == 0);
    r.last       = lst;
    pending_results.push_back(r);
  endfunction

  // Work out the results one accepted request beat owes, and update the ring.
  function automatic void predict_queue_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] din,
                                           logic [AMT_W-1:0] req_in, logic fin);
    int unsigned       req, held, n, idx;
    logic [DATA_W-1:0] peeked [$];
    req = (req_in > MAX_REQ_DEF) ? MAX_REQ_DEF : 32'(req_in);
    if (op == OP_PUSH) begin
      // first byte of a run decides: the whole length fits or the run is refused
      if (!run_open) begin
        run_open    = 1;
        run_stored  = 0;
        run_len     = req;
        run_refused = (req > free_slots);
      end
      // bytes past the run length are dropped
      if (!run_refused && run_stored < run_len && free_slots > 0) begin
        ring_mem[wr_ptr] = din;
        wr_ptr = ring_next(wr_ptr);
        free_slots--;
        run_stored++;
      end
      if (fin) begin
        owe_result(run_refused ? ST_NO_ROOM : ST_OK, '0, run_refused ? 0 : run_stored, 1'b1);
        close_run();
      end
      return;
    end
    // any other op ends an open run silently; stored bytes stay
    close_run();
    if (op == OP_PEEK || op == OP_POP || op == OP_PEEK_POP) begin
      held = ring_cap - free_slots;
      n    = (req > held) ? held : req;
      idx  = rd_ptr;
      for (int i = 0; i < n; i++) begin
        peeked.push_back(ring_mem[idx]);
        idx = ring_next(idx);
      end
      if (op != OP_PEEK) begin
        rd_ptr = idx;
        free_slots += n;
      end
      if (op == OP_POP || n == 0) owe_result(ST_OK, '0, n, 1'b1);
      else foreach (peeked[i]) owe_result(ST_OK, peeked[i], n, i == n - 1);
    end else begin
      if (op == OP_CLEAR) empty_ring();
      owe_result(ST_OK, '0, 0, 1'b1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting
  // ---------------------------------------------------------------------------
  function automatic string fmt_result(result_t r);
    return $sformatf("st=%0d data=%02h amt=%0d free=%0d empty=%0b full=%0b last=%0b",
                     r.status, r.data, r.amount, r.free_space, r.is_empty, r.is_full, r.last);
  endfunction

  task automatic note_fail(string what, string detail);
    fail_cnt++;
    if (fail_cnt <= 10) $display("[%0t] ERROR %s: %s", $realtime, what, detail);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------------
  function automatic result_t res(logic st, logic [DATA_W-1:0] d, int amt, int fr,
                                  logic e, logic f, logic l);
    result_t r;
    r = {st, d, amt[AMT_W-1:0], fr[CAP_W-1:0], e, f, l};
    return r;
  endfunction

  function automatic step_t row(logic [OP_W-1:0] op, int din, int req, logic fin);
    step_t s;
    s.is_cfg  = 1'b0;
    s.cfg_val = '0;
    s.op      = op;
    s.din     = DATA_W'(din);
    s.req     = AMT_W'(req);
    s.fin     = fin;
    s.fixed   = 1'b0;
    s.want    = '0;
    return s;
  endfunction

  function automatic step_t row_fix(logic [OP_W-1:0] op, int din, int req, logic fin,
                                    result_t w);
    step_t s;
    s       = row(op, din, req, fin);
    s.fixed = 1'b1;
    s.want  = w;
    return s;
  endfunction

  function automatic step_t row_cfg(int v);
    step_t s;
    s         = row(OP_CLEAR, 0, 0, 1'b0);
    s.is_cfg  = 1'b1;
    s.cfg_val = CAP_W'(v);
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Present one request beat, after a random gap, and hold it until taken.
  // tvalid stays high on return so back-to-back beats need no second write.
  task automatic send_beat(logic [OP_W-1:0] op, logic [DATA_W-1:0] din,
                           logic [AMT_W-1:0] req, logic fin,
                           logic fixed = 1'b0, result_t want = '0);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, req, din};
    s_axis_tlast  <= fin;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    predict_queue_op(op, din, req, fin);
    if (fixed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(want);
    end
    beats_sent++;
  endtask

  // Capacity is written only with the block idle: all results in, plus a wait for a trailing
  // push byte that owes no result.
  task automatic write_capacity(logic [CAP_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    apply_capacity(v);
    cfg_we <= 1'b0;
  endtask

  // Random requests until the beat count reaches the goal.
  task automatic random_phase(int beat_goal);
    int unsigned pick, len, nbytes, req;
    bit          cut;
    while (beats_sent < beat_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len    = $urandom_range(0, 12);
        req    = len;
        nbytes = (len == 0) ? 1 : len;
        if ($urandom_range(0, 9) == 0) nbytes += 2;  // bytes past the run length
        cut = ($urandom_range(0, 9) == 0);           // run left open
        for (int b = 0; b < nbytes; b++) begin
          send_beat(OP_PUSH, DATA_W'($urandom()), AMT_W'(req), !cut && (b == nbytes - 1));
        end
      end else if (pick < 87) begin
        if ($urandom_range(0, 99) < 8) req = $urandom_range(MAX_REQ_DEF + 1, 127);
        else if ($urandom_range(0, 99) < 10) req = $urandom_range(20, MAX_REQ_DEF);
        else req = $urandom_range(0, 10);
        case ($urandom_range(0, 2))
          0:       send_beat(OP_PEEK, '0, AMT_W'(req), 1'b0);
          1:       send_beat(OP_POP, '0, AMT_W'(req), 1'b0);
          default: send_beat(OP_PEEK_POP, '0, AMT_W'(req), 1'b0);
        endcase
      end else if (pick < 92) begin
        send_beat(OP_CLEAR, '0, '0, 1'b0);
      end else if (pick < 96) begin
        case ($urandom_range(0, 2))
          0:       send_beat(OP_RSVD5, DATA_W'($urandom()), '0, 1'b0);
          1:       send_beat(OP_RSVD6, DATA_W'($urandom()), '0, 1'b0);
          default: send_beat(OP_RSVD7, DATA_W'($urandom()), '0, 1'b0);
        endcase
      end else begin
        case ($urandom_range(0, 3))
          0:       write_capacity(CAP_W'($urandom_range(1, 16)));
          1:       write_capacity('0);
          2:       write_capacity(CAP_W'(DEPTH_DEF));
          default: write_capacity(CAP_W'($urandom_range(DEPTH_DEF + 1, 2047)));
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, receiver and monitor
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      mon_got = {m_axis_tdata[0], m_axis_tdata[8:1], m_axis_tdata[15:9],
                 m_axis_tdata[26:16], m_axis_tdata[27], m_axis_tdata[28], m_axis_tlast};
      if (pending_results.size() == 0) begin
        note_fail("unexpected beat", fmt_result(mon_got));
      end else begin
        mon_exp = pending_results.pop_front();
        if (mon_got !== mon_exp) begin
          note_fail("mismatch", $sformatf("expected %s, got %s",
                                          fmt_result(mon_exp), fmt_result(mon_got)));
        end
      end
    end
  end

  // run limit, far above a run of full-length peeks under the longest stalls
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= '0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    apply_capacity(CAP_W'(CAP_RESET));

    // after reset: an empty read and an unused op
    dir_tab.push_back(row_fix(OP_PEEK, 0, 4, 1'b0, res(ST_OK, 0, 0, 1024, 1, 0, 1)));
    dir_tab.push_back(row_fix(OP_RSVD5, 0, 0, 1'b0, res(ST_OK, 0, 0, 1024, 1, 0, 1)));
    // small ring, a run of three and a peek
    dir_tab.push_back(row_cfg(8));
    dir_tab.push_back(row(OP_PUSH, 'hA1, 3, 1'b0));
    dir_tab.push_back(row(OP_PUSH, 'hB2, 3, 1'b0));
    dir_tab.push_back(row(OP_PUSH, 'hC3, 3, 1'b1));
    dir_tab.push_back(row(OP_PEEK, 0, 2, 1'b0));
    // run longer than the free space is refused
    dir_tab.push_back(row(OP_PUSH, 'h11, 6, 1'b0));
    dir_tab.push_back(row_fix(OP_PUSH, 'h22, 6, 1'b1, res(ST_NO_ROOM, 0, 0, 5, 0, 0, 1)));
    // fill to the brim
    dir_tab.push_back(row(OP_PUSH, 'h31, 5, 1'b0));
    dir_tab.push_back(row(OP_PUSH, 'h32, 5, 1'b0));
    dir_tab.push_back(row(OP_PUSH, 'h33, 5, 1'b0));
    dir_tab.push_back(row(OP_PUSH, 'h34, 5, 1'b0));
    dir_tab.push_back(row_fix(OP_PUSH, 'h35, 5, 1'b1, res(ST_OK, 0, 5, 0, 0, 1, 1)));
    // zero-length run on a full ring
    dir_tab.push_back(row_fix(OP_PUSH, 'h00, 0, 1'b1, res(ST_OK, 0, 0, 0, 0, 1, 1)));
    dir_tab.push_back(row(OP_PEEK_POP, 0, 4, 1'b0));
    // extra bytes past the run length, written after the write index has wrapped
    dir_tab.push_back(row(OP_PUSH, 'h51, 3, 1'b0));
    dir_tab.push_back(row(OP_PUSH, 'h52, 3, 1'b0));
    dir_tab.push_back(row(OP_PUSH, 'h53, 3, 1'b0));
    dir_tab.push_back(row(OP_PUSH, 'h54, 3, 1'b0));
    dir_tab.push_back(row(OP_PUSH, 'h55, 3, 1'b1));
    // run cut short by an oversized pop
    dir_tab.push_back(row(OP_PUSH, 'h61, 2, 1'b0));
    dir_tab.push_back(row(OP_POP, 0, 100, 1'b0));
    dir_tab.push_back(row_fix(OP_CLEAR, 0, 0, 1'b0, res(ST_OK, 0, 0, 8, 1, 0, 1)));
    // capacity 0 acts as 1
    dir_tab.push_back(row_cfg(0));
    dir_tab.push_back(row_fix(OP_PUSH, 'h77, 1, 1'b1, res(ST_OK, 0, 1, 0, 0, 1, 1)));
    dir_tab.push_back(row(OP_PEEK, 0, 1, 1'b0));
    // capacity past the depth acts as the depth
    dir_tab.push_back(row_cfg(2000));
    dir_tab.push_back(row_fix(OP_POP, 0, 5, 1'b0, res(ST_OK, 0, 0, 1024, 1, 0, 1)));
    dir_tab.push_back(row_fix(OP_RSVD7, 0, 0, 1'b0, res(ST_OK, 0, 0, 1024, 1, 0, 1)));

    send_idle_pct = 38;
    recv_idle_pct = 53;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[k]) begin
      if (dir_tab[k].is_cfg) begin
        write_capacity(dir_tab[k].cfg_val);
      end else begin
        send_beat(dir_tab[k].op, dir_tab[k].din, dir_tab[k].req, dir_tab[k].fin,
                  dir_tab[k].fixed, dir_tab[k].want);
      end
    end

    write_capacity(CAP_W'(12));
    random_phase(100);
    send_idle_pct = 53;
    recv_idle_pct = 38;
    random_phase(165);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(230);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
